@@ sv/lidar_sector_obstacle_avoid_assert.svh @@
// Assertion macros for the lidar sector obstacle avoidance block.
// Used by the port checker; depends on nothing else.
`ifndef LIDAR_SECTOR_OBSTACLE_AVOID_ASSERT_SVH
`define LIDAR_SECTOR_OBSTACLE_AVOID_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSOA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsoa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsoa: next-cycle check failed");

`endif

@@ sv/lsoa_pkg.sv @@
// Shared types and constants for the lidar sector obstacle avoidance block.
// No dependencies; every file but the assertion header refers to it by scoped names.
`timescale 1ns / 1ps

package lsoa_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned RANGE_BITS = 16;

  // Configuration register indexes, in register-map order.
  typedef enum logic [2:0] {
    REG_CRUISE_SPEED     = 3'd0,
    REG_SPIN_RATE        = 3'd1,
    REG_SAFE_DISTANCE    = 3'd2,
    REG_HEADING_REF      = 3'd3,
    REG_FIRST_BEAM_ANGLE = 3'd4,
    REG_BEAM_STEP        = 3'd5,
    REG_MIN_VALID_RANGE  = 3'd6,
    REG_MAX_VALID_RANGE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [15:0] cruise_speed;
    logic        [14:0] spin_rate;
    logic        [15:0] safe_distance;
    logic signed [15:0] heading_ref;
    logic signed [15:0] first_beam_angle;
    logic signed [15:0] beam_step;
    logic        [15:0] min_valid_range;
    logic        [15:0] max_valid_range;
  } cfg_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        range_invalid;
    logic        last_in_scan;
  } in_t;

  typedef struct packed {
    logic        [15:0] linear_speed;
    logic signed [15:0] angular_rate;
    logic        [15:0] front_distance;
    logic        [15:0] left_distance;
    logic        [15:0] right_distance;
  } out_t;

  // Classified sample passed from the front end to the back end.
  typedef struct packed {
    logic [15:0] range_mm;
    logic        hit_front;
    logic        hit_left;
    logic        hit_right;
    logic        first;
    logic        last;
  } sample_t;

  // Sign-extend a 16-bit register angle, then wrap it to ANGLE_BITS.
  function automatic logic [ANGLE_BITS-1:0] reg_angle(input logic [15:0] v);
    logic [31:0] s;
    s = {{16{v[15]}}, v};
    return s[ANGLE_BITS-1:0];
  endfunction

endpackage

@@ sv/lsoa_front.sv @@
// Front end: accepts lidar samples, tracks the beam angle and classifies each
// sample into sectors. Depends on lsoa_pkg.
`timescale 1ns / 1ps

module lsoa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsoa_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  lsoa_pkg::in_t     in_data_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output lsoa_pkg::sample_t entry_o
);

  localparam int unsigned AB = lsoa_pkg::ANGLE_BITS;
  localparam int unsigned PW = AB + 10;
  localparam logic signed [PW-1:0] FULL     = PW'(1) << AB;
  localparam logic signed [PW-1:0] SCALE    = PW'(360);
  localparam logic signed [PW-1:0] FRONT_LO = -(FULL * PW'(10));
  localparam logic signed [PW-1:0] FRONT_HI = FULL * PW'(10);
  localparam logic signed [PW-1:0] SIDE_LO  = FULL * PW'(40);
  localparam logic signed [PW-1:0] SIDE_HI  = FULL * PW'(70);
  localparam logic [15:0] RANGE_MASK = 16'((64'(1) << lsoa_pkg::RANGE_BITS) - 64'(1));

  logic [AB-1:0]        beam_q, beam_d;
  logic                 in_scan_q, in_scan_d;
  logic [AB-1:0]        angle;
  logic [AB-1:0]        rel;
  logic signed [PW-1:0] rel_ext;
  logic signed [PW-1:0] prod;
  logic [15:0]          r;
  logic                 ok;

  assign push_o = in_valid_i && q_ready_i;

  // Scan start takes the first beam angle from the register.
  assign angle   = in_scan_q ? beam_q : lsoa_pkg::reg_angle(cfg_i.first_beam_angle);
  assign rel     = angle - lsoa_pkg::reg_angle(cfg_i.heading_ref);
  assign rel_ext = {{(PW-AB){rel[AB-1]}}, rel};
  assign prod    = rel_ext * SCALE;

  assign r  = in_data_i.range_mm & RANGE_MASK;
  assign ok = !in_data_i.range_invalid && (r > cfg_i.min_valid_range)
              && (r < cfg_i.max_valid_range);

  always_comb begin
    entry_o.range_mm  = r;
    entry_o.hit_front = ok && (prod >= FRONT_LO) && (prod <= FRONT_HI);
    entry_o.hit_left  = ok && (prod >= SIDE_LO) && (prod <= SIDE_HI);
    entry_o.hit_right = ok && (prod >= -SIDE_HI) && (prod <= -SIDE_LO);
    entry_o.first     = !in_scan_q;
    entry_o.last      = in_data_i.last_in_scan;
  end

  always_comb begin
    beam_d    = beam_q;
    in_scan_d = in_scan_q;
    if (push_o) begin
      beam_d    = angle + lsoa_pkg::reg_angle(cfg_i.beam_step);
      in_scan_d = !in_data_i.last_in_scan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_scan_q <= 1'b0;
    end else begin
      in_scan_q <= in_scan_d;
    end
  end

  // Angle is only read mid-scan, so it needs no reset.
  always_ff @(posedge clk_i) begin
    beam_q <= beam_d;
  end

endmodule

@@ sv/lsoa_queue.sv @@
// Two-entry queue of classified samples between front and back end.
// Depends on lsoa_pkg.
`timescale 1ns / 1ps

module lsoa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lsoa_pkg::sample_t entry_i,
  output logic              ready_o,
  output logic              valid_o,
  output lsoa_pkg::sample_t entry_o,
  input  logic              pop_i
);

  lsoa_pkg::sample_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ sv/lsoa_back.sv @@
// Back end: folds classified samples into the sector minima and issues the
// drive command on the last sample of a scan. Depends on lsoa_pkg.
`timescale 1ns / 1ps

module lsoa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsoa_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  lsoa_pkg::sample_t q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsoa_pkg::out_t    out_data_o
);

  logic [15:0]    front_q, front_d;
  logic [15:0]    left_q, left_d;
  logic [15:0]    right_q, right_d;
  logic [15:0]    base_f, base_l, base_r;
  logic           out_valid_q, out_valid_d;
  lsoa_pkg::out_t out_q, out_d;
  logic [15:0]    r;

  // Hold a last sample while an unread result still occupies the output.
  assign q_pop_o = q_valid_i && (!q_entry_i.last || !out_valid_q || out_ready_i);

  assign r      = q_entry_i.range_mm;
  assign base_f = q_entry_i.first ? cfg_i.max_valid_range : front_q;
  assign base_l = q_entry_i.first ? cfg_i.max_valid_range : left_q;
  assign base_r = q_entry_i.first ? cfg_i.max_valid_range : right_q;

  always_comb begin
    front_d = (q_entry_i.hit_front && (r < base_f)) ? r : base_f;
    left_d  = (q_entry_i.hit_left  && (r < base_l)) ? r : base_l;
    right_d = (q_entry_i.hit_right && (r < base_r)) ? r : base_r;

    out_d.front_distance = front_d;
    out_d.left_distance  = left_d;
    out_d.right_distance = right_d;
    if (front_d < cfg_i.safe_distance) begin
      out_d.linear_speed = 16'd0;
      if (left_d > right_d) begin
        out_d.angular_rate = -$signed({1'b0, cfg_i.spin_rate});
      end else begin
        out_d.angular_rate = $signed({1'b0, cfg_i.spin_rate});
      end
    end else begin
      out_d.linear_speed = cfg_i.cruise_speed;
      out_d.angular_rate = 16'sd0;
    end

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o && q_entry_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Minima reload at every scan start, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      front_q <= front_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
    if (q_pop_o && q_entry_i.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/lidar_sector_obstacle_avoid.sv @@
// Flow: an accepted sample is written into the sample queue; the back end pops it
// from there and registers the result of a last sample into the output register.
// Throughput: one sample per cycle unless the output stalls, set by the classify
// and min update; a stalled output backs up through the two-entry sample queue.
// Reset: registers take their defaults, scan state is cleared, queue and output
// are empty. No clearing pass; the block accepts samples right after reset.
`timescale 1ns / 1ps

module lidar_sector_obstacle_avoid (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration write channel
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  // sample input channel
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsoa_pkg::in_t  in_data_i,
  // drive command output channel
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lsoa_pkg::out_t out_data_o
);

  lsoa_pkg::cfg_t    cfg_q, cfg_d;
  logic              push;
  lsoa_pkg::sample_t push_entry;
  logic              q_ready;
  logic              q_valid;
  lsoa_pkg::sample_t q_entry;
  logic              q_pop;

  // Register writes are always taken; software must write only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (lsoa_pkg::reg_idx_e'(cfg_index_i))
        lsoa_pkg::REG_CRUISE_SPEED:     cfg_d.cruise_speed     = cfg_data_i;
        lsoa_pkg::REG_SPIN_RATE:        cfg_d.spin_rate        = cfg_data_i[14:0];
        lsoa_pkg::REG_SAFE_DISTANCE:    cfg_d.safe_distance    = cfg_data_i;
        lsoa_pkg::REG_HEADING_REF:      cfg_d.heading_ref      = $signed(cfg_data_i);
        lsoa_pkg::REG_FIRST_BEAM_ANGLE: cfg_d.first_beam_angle = $signed(cfg_data_i);
        lsoa_pkg::REG_BEAM_STEP:        cfg_d.beam_step        = $signed(cfg_data_i);
        lsoa_pkg::REG_MIN_VALID_RANGE:  cfg_d.min_valid_range  = cfg_data_i;
        lsoa_pkg::REG_MAX_VALID_RANGE:  cfg_d.max_valid_range  = cfg_data_i;
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed     <= 16'd200;
      cfg_q.spin_rate        <= 15'd450;
      cfg_q.safe_distance    <= 16'd2000;
      cfg_q.heading_ref      <= 16'sd0;
      cfg_q.first_beam_angle <= 16'sh8000;
      cfg_q.beam_step        <= 16'sd182;
      cfg_q.min_valid_range  <= 16'd120;
      cfg_q.max_valid_range  <= 16'd12000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input ready follows queue space only, never the output side directly.
  assign in_ready_o = q_ready;

  // Front end: beam angle tracking and sector classification.
  lsoa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Decouple the two ends so an output stall does not stop sampling at once.
  lsoa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  // Back end: sector minima and the drive decision.
  lsoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/lsoa_checker.sv @@
// Port-level checker for the lidar sector obstacle avoidance block, bound to
// the top level. Depends on lsoa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lidar_sector_obstacle_avoid_assert.svh"

module lsoa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lsoa_pkg::out_t out_data_o
);

  // Hold a pending transaction until it is taken.
  `LSOA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `LSOA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  // A turn command never carries forward motion.
  `LSOA_ASSERT_SAME(a_turn_stops, clk_i, rst_ni, out_valid_o && (out_data_o.angular_rate != 16'sd0), out_data_o.linear_speed == 16'd0)
  // Turn rate comes from a 15-bit magnitude, so the most negative code is unreachable.
  `LSOA_ASSERT_SAME(a_rate_range, clk_i, rst_ni, out_valid_o, out_data_o.angular_rate != 16'sh8000)

endmodule

bind lidar_sector_obstacle_avoid lsoa_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
